[sv/rsst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsst_pkg
// Shared types and constants of the range-sum segment tree: item structs,
// operation and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package rsst_pkg;

   localparam int POS_W  = 11;
   localparam int DATA_W = 32;

   localparam logic [POS_W-1:0] ACTIVE_LENGTH_RESET = 11'd1024;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_QUERY  = 1'b1
   } opcode_type;

   typedef enum logic {
      STATUS_DONE      = 1'b0,
      STATUS_RANGE_ERR = 1'b1
   } status_type;

   typedef struct packed {
      opcode_type               opcode;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] new_value;
      logic [POS_W-1:0]         range_low;
      logic [POS_W-1:0]         range_high;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] range_sum;
      status_type               status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_WRITE,
      ST_UPD_ADD,
      ST_QRY_LEFT,
      ST_QRY_RIGHT,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

[sv/rsst_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsst_mem
// Node store of the tree: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module rsst_mem #(
   parameter int DEPTH = 2048
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  wire logic [rsst_pkg::DATA_W-1:0]   wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic      [rsst_pkg::DATA_W-1:0]   rd_data
);
   import rsst_pkg::*;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/range_sum_segment_tree.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// range_sum_segment_tree
// Segment tree of wrapping 32-bit sums with point updates and range queries.
// ----------------------------------------------------------------------------
// The tree lives in one node memory of 2*MAX_ELEMENTS words (leaf p at node
// MAX_ELEMENTS+p-1, node i the sum of nodes 2i and 2i+1) and is walked one
// level at a time by a small sequencer. The memory has a single read port
// with registered read data, so at each tree level an update writes the
// node and reads its sibling, then adds, and a query reads the left border
// node and then the right border node. A finished item waits until the
// result register is free. Items are handled one at a time; req_stall is
// high while one is in flight. After reset the memory is swept to zero,
// one node per cycle, over all 2*MAX_ELEMENTS nodes with req_stall high;
// csr writes are taken at any time. The result register lets a new item
// in while a result still waits.
// ----------------------------------------------------------------------------
module range_sum_segment_tree #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire rsst_pkg::req_type            req_data,
   // response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output rsst_pkg::rsp_type                 rsp_data,
   // configuration: active_length
   input  wire logic                         csr_wr_en,
   input  wire logic [rsst_pkg::POS_W-1:0]   csr_wr_data
);
   import rsst_pkg::*;

   localparam int DEPTH = 2 * MAX_ELEMENTS;
   localparam int AW    = $clog2(DEPTH);
   // node index width: must hold 2*MAX_ELEMENTS (one past the last node)
   localparam int IW    = $clog2(DEPTH + 1);
   // length compare width
   localparam int LW    = (POS_W > $clog2(MAX_ELEMENTS + 1)) ? POS_W
                                                              : $clog2(MAX_ELEMENTS + 1);
   localparam logic [LW-1:0] MAX_LEN   = LW'(MAX_ELEMENTS);
   localparam logic [IW-1:0] LEAF_BASE = IW'(MAX_ELEMENTS);
   localparam logic [AW-1:0] LAST_NODE = AW'(DEPTH - 1);

   state_type             state_ff, state_in;
   logic [POS_W-1:0]      active_length_ff;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [IW-1:0]         a_ff, a_in;      // left border, or node of an update
   logic [IW-1:0]         b_ff, b_in;      // right border (exclusive)
   logic [DATA_W-1:0]     acc_ff, acc_in;  // running sum, or value being carried up
   logic                  pend_ff, pend_in; // read data to be added this cycle
   opcode_type            op_ff, op_in;
   status_type            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // memory port
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [DATA_W-1:0]     mem_wdata;
   logic [AW-1:0]         mem_raddr;
   logic [DATA_W-1:0]     mem_rdata;

   // request decode
   logic [LW-1:0]         eff_len;
   logic [LW-1:0]         pos_ext;
   logic [LW-1:0]         lo_clip;
   logic [LW-1:0]         hi_clip;
   logic                  upd_ok;
   logic                  qry_nonempty;
   logic [IW-1:0]         sib_node;
   logic [IW-1:0]         b_dec;
   logic [DATA_W-1:0]     acc_sum;
   logic                  out_free;

   rsst_mem #(
      .DEPTH(DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // active length clipped to capacity
   assign eff_len = (LW'(active_length_ff) > MAX_LEN) ? MAX_LEN : LW'(active_length_ff);
   assign pos_ext = LW'(req_data.position);
   assign upd_ok  = (pos_ext != '0) && (pos_ext <= eff_len);

   // query bounds clipped to 1..eff_len
   assign lo_clip = (req_data.range_low == '0) ? LW'(1) : LW'(req_data.range_low);
   assign hi_clip = (LW'(req_data.range_high) > eff_len) ? eff_len
                                                          : LW'(req_data.range_high);
   assign qry_nonempty = (lo_clip <= hi_clip);

   assign sib_node = a_ff ^ IW'(1);
   assign b_dec    = b_ff - IW'(1);
   assign acc_sum  = acc_ff + (pend_ff ? mem_rdata : '0);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_ff           <= '0;
         pend_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         active_length_ff <= ACTIVE_LENGTH_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            active_length_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      acc_ff      <= acc_in;
      op_ff       <= op_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_sum;
      pend_in      = 1'b0;
      op_in        = op_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_waddr    = a_ff[AW-1:0];
      mem_wdata    = acc_ff;
      mem_raddr    = a_ff[AW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            // zero sweep over the node memory
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.opcode;
               status_in = STATUS_DONE;
               if (req_data.opcode == OP_UPDATE) begin
                  acc_in = req_data.new_value;
                  a_in   = LEAF_BASE + IW'(pos_ext) - IW'(1);
                  if (upd_ok) begin
                     state_in = ST_UPD_WRITE;
                  end else begin
                     status_in = STATUS_RANGE_ERR;
                     state_in  = ST_DONE;
                  end
               end else begin
                  acc_in = '0;
                  a_in   = LEAF_BASE + IW'(lo_clip) - IW'(1);
                  b_in   = LEAF_BASE + IW'(hi_clip);
                  state_in = qry_nonempty ? ST_QRY_LEFT : ST_DONE;
               end
            end
         end

         ST_UPD_WRITE: begin
            // store the node, fetch its sibling
            mem_we    = 1'b1;
            mem_waddr = a_ff[AW-1:0];
            mem_wdata = acc_ff;
            mem_raddr = sib_node[AW-1:0];
            if (a_ff == IW'(1)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_UPD_ADD;
            end
         end

         ST_UPD_ADD: begin
            // parent sum, one level up
            acc_in   = acc_ff + mem_rdata;
            a_in     = a_ff >> 1;
            state_in = ST_UPD_WRITE;
         end

         ST_QRY_LEFT: begin
            if (a_ff >= b_ff) begin
               state_in = ST_DONE;
            end else begin
               if (a_ff[0]) begin
                  // left border node is a right child: take it, step right
                  mem_raddr = a_ff[AW-1:0];
                  pend_in   = 1'b1;
                  a_in      = a_ff + IW'(1);
               end
               state_in = ST_QRY_RIGHT;
            end
         end

         ST_QRY_RIGHT: begin
            if (b_ff[0]) begin
               // right border is odd: take the node just left of it
               mem_raddr = b_dec[AW-1:0];
               pend_in   = 1'b1;
            end
            a_in     = a_ff >> 1;
            b_in     = b_ff >> 1;
            state_in = ST_QRY_LEFT;
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.range_sum = (op_ff == OP_QUERY) ? $signed(acc_sum) : '0;
               rsp_data_in.status    = status_ff;
               state_in              = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
